// ===== sv/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, codes and helpers of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int TIME_W   = 32;
  localparam int DELAY_W  = 31;
  localparam int CLIENT_W = 8;
  localparam int OP_W     = 2;

  // Operation codes of an input transaction.
  localparam logic [OP_W-1:0] OP_SUBSCRIBE   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNSUBSCRIBE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK        = 2'd2;

  // Kinds of an output transaction.
  localparam logic EV_EXPIRED = 1'b0;
  localparam logic EV_REJECT  = 1'b1;

  typedef logic [TIME_W-1:0] time_t;

  // True when deadline a lies strictly before deadline b, modulo 2^32.
  function automatic logic earlier(input time_t a, input time_t b);
    time_t diff;
    diff = a - b;
    return diff[TIME_W-1];
  endfunction

endpackage

// ===== sv/deadline_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_top
// Sorted queue of one-shot timers, kept in a single-port-write memory.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one command per transaction: subscribe (client id
// and delay), unsubscribe (client id) or a one-millisecond tick. The output
// channel returns expiry events in deadline order and full-queue rejections;
// last_of_run_o marks the final event caused by one command.
// The entries live in a memory with a registered read port, so every step
// is a read, then a compare or a write back in the cycle after. A subscribe
// or unsubscribe scans all N pending entries, then, if the list changes,
// moves the entries between the old and new slot at one per cycle; a
// subscribe then writes the new entry. A tick reads the head entries while
// they are due, then closes the gap left by the k expired ones. The input
// stall is high while a command is in work. The output register lets the
// next command be taken while an event waits; while the receiver stalls,
// the sequencer holds at the next event it needs to hand over. Reset empties
// the queue and clears the millisecond counter; the memory itself is not
// cleared.
// ----------------------------------------------------------------------------
module deadline_timer_queue_top
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [CLIENT_W-1:0] client_id_i,
  input  logic [DELAY_W-1:0]  delay_ms_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                event_kind_o,
  output logic [CLIENT_W-1:0] due_id_o,
  output logic                last_of_run_o
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W  = (ID_BITS < CLIENT_W) ? ID_BITS : CLIENT_W;
  localparam int ENT_W = TIME_W + ID_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_PLAN    = 4'd2;
  localparam logic [3:0] S_SWEEP   = 4'd3;
  localparam logic [3:0] S_INS     = 4'd4;
  localparam logic [3:0] S_REJ     = 4'd5;
  localparam logic [3:0] S_EXP_RD  = 4'd6;
  localparam logic [3:0] S_EXP_CHK = 4'd7;
  localparam logic [3:0] S_EXP_END = 4'd8;

  // Entry memory.
  logic [ENT_W-1:0] mem_q [QUEUE_DEPTH];
  logic [ENT_W-1:0] rd_data_q;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0] wr_data;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  time_t            time_q, time_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [ID_W-1:0]  id_q, id_d;
  time_t            dl_q, dl_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] chk_q, chk_d;
  logic             rdv_q, rdv_d;
  logic             found_q, found_d;
  logic             qset_q, qset_d;
  logic [IDX_W-1:0] p_q, p_d;
  logic [CNT_W-1:0] q_q, q_d;
  logic [IDX_W-1:0] sw_src_q, sw_src_d;
  logic [IDX_W-1:0] sw_dst_q, sw_dst_d;
  logic [CNT_W-1:0] sw_left_q, sw_left_d;
  logic [CNT_W-1:0] sw_k_q, sw_k_d;
  logic             sw_up_q, sw_up_d;
  logic             sw_ins_q, sw_ins_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             hold_vld_q, hold_vld_d;
  logic [ID_W-1:0]  hold_id_q, hold_id_d;

  logic             out_valid_q, out_valid_d;
  logic             out_kind_q;
  logic [ID_W-1:0]  out_id_q;
  logic             out_last_q;

  logic             push, push_kind, push_last;
  logic [ID_W-1:0]  push_id;
  logic             out_free, in_accept;
  time_t            rd_dl;
  logic [ID_W-1:0]  rd_id;
  logic [CNT_W-1:0] qf, cnt_m1, dst_dn;

  assign rd_dl  = rd_data_q[ENT_W-1 -: TIME_W];
  assign rd_id  = rd_data_q[ID_W-1:0];
  assign cnt_m1 = count_q - CNT_W'(1);
  assign dst_dn = CNT_W'(sw_src_q) - sw_k_q;
  // Insert slot counted in the list without the replaced entry.
  assign qf     = qset_q ? q_q : (count_q - CNT_W'(found_q));

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    time_d     = time_q;
    op_d       = op_q;
    id_d       = id_q;
    dl_d       = dl_q;
    idx_d      = idx_q;
    chk_d      = chk_q;
    rdv_d      = rdv_q;
    found_d    = found_q;
    qset_d     = qset_q;
    p_d        = p_q;
    q_d        = q_q;
    sw_src_d   = sw_src_q;
    sw_dst_d   = sw_dst_q;
    sw_left_d  = sw_left_q;
    sw_k_d     = sw_k_q;
    sw_up_d    = sw_up_q;
    sw_ins_d   = sw_ins_q;
    n_d        = n_q;
    hold_vld_d = hold_vld_q;
    hold_id_d  = hold_id_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    push       = 1'b0;
    push_kind  = EV_EXPIRED;
    push_id    = hold_id_q;
    push_last  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d       = operation_i;
          id_d       = ID_W'(client_id_i);
          dl_d       = time_q + TIME_W'(delay_ms_i);
          idx_d      = '0;
          found_d    = 1'b0;
          qset_d     = 1'b0;
          rdv_d      = 1'b0;
          n_d        = '0;
          hold_vld_d = 1'b0;
          if (operation_i inside {OP_SUBSCRIBE, OP_UNSUBSCRIBE}) begin
            state_d = S_SCAN;
          end else if (operation_i == OP_TICK) begin
            time_d  = time_q + TIME_W'(1);
            state_d = S_EXP_RD;
          end
        end
      end

      S_SCAN: begin
        rdv_d = 1'b0;
        if (idx_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[IDX_W-1:0];
          rdv_d   = 1'b1;
          chk_d   = idx_q[IDX_W-1:0];
          idx_d   = idx_q + CNT_W'(1);
        end
        if (rdv_q) begin
          if (rd_id == id_q && !found_q) begin
            found_d = 1'b1;
            p_d     = chk_q;
          end else if (op_q == OP_SUBSCRIBE && !qset_q && earlier(dl_q, rd_dl)) begin
            qset_d = 1'b1;
            q_d    = CNT_W'(chk_q) - CNT_W'(found_q);
          end
        end
        if (!(idx_q < count_q) && !rdv_q) begin
          state_d = S_PLAN;
        end
      end

      S_PLAN: begin
        sw_k_d = CNT_W'(1);
        if (op_q == OP_UNSUBSCRIBE) begin
          if (found_q) begin
            sw_up_d   = 1'b0;
            sw_src_d  = p_q + IDX_W'(1);
            sw_left_d = cnt_m1 - CNT_W'(p_q);
            count_d   = cnt_m1;
            sw_ins_d  = 1'b0;
            state_d   = S_SWEEP;
          end else begin
            state_d = S_IDLE;
          end
        end else if (!found_q && count_q == CNT_W'(QUEUE_DEPTH)) begin
          state_d = S_REJ;
        end else begin
          q_d      = qf;
          sw_ins_d = 1'b1;
          state_d  = S_SWEEP;
          if (found_q && qf >= CNT_W'(p_q)) begin
            // New slot at or after the old one: close up towards the old slot.
            sw_up_d   = 1'b0;
            sw_src_d  = p_q + IDX_W'(1);
            sw_left_d = qf - CNT_W'(p_q);
          end else if (found_q) begin
            sw_up_d   = 1'b1;
            sw_src_d  = p_q - IDX_W'(1);
            sw_left_d = CNT_W'(p_q) - qf;
          end else begin
            sw_up_d   = 1'b1;
            sw_src_d  = cnt_m1[IDX_W-1:0];
            sw_left_d = count_q - qf;
          end
        end
      end

      S_SWEEP: begin
        // One read issued and one earlier read written back per cycle.
        rdv_d = 1'b0;
        if (sw_left_q != '0) begin
          rd_en     = 1'b1;
          rd_addr   = sw_src_q;
          rdv_d     = 1'b1;
          sw_dst_d  = sw_up_q ? (sw_src_q + IDX_W'(1)) : dst_dn[IDX_W-1:0];
          sw_src_d  = sw_up_q ? (sw_src_q - IDX_W'(1)) : (sw_src_q + IDX_W'(1));
          sw_left_d = sw_left_q - CNT_W'(1);
        end
        if (rdv_q) begin
          wr_en   = 1'b1;
          wr_addr = sw_dst_q;
          wr_data = rd_data_q;
        end
        if (sw_left_q == '0 && !rdv_q) begin
          state_d = sw_ins_q ? S_INS : S_IDLE;
        end
      end

      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = q_q[IDX_W-1:0];
        wr_data = {dl_q, id_q};
        if (!found_q) begin
          count_d = count_q + CNT_W'(1);
        end
        state_d = S_IDLE;
      end

      S_REJ: begin
        if (out_free) begin
          push      = 1'b1;
          push_kind = EV_REJECT;
          push_id   = id_q;
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_EXP_RD: begin
        if (idx_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[IDX_W-1:0];
          state_d = S_EXP_CHK;
        end else begin
          state_d = S_EXP_END;
        end
      end

      S_EXP_CHK: begin
        // The held event is sent once it is known that another one follows.
        if (!earlier(time_q, rd_dl)) begin
          if (!hold_vld_q || out_free) begin
            push       = hold_vld_q;
            hold_id_d  = rd_id;
            hold_vld_d = 1'b1;
            n_d        = n_q + CNT_W'(1);
            idx_d      = idx_q + CNT_W'(1);
            state_d    = S_EXP_RD;
          end
        end else begin
          state_d = S_EXP_END;
        end
      end

      S_EXP_END: begin
        if (!hold_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          hold_vld_d = 1'b0;
          sw_up_d    = 1'b0;
          sw_k_d     = n_q;
          sw_src_d   = n_q[IDX_W-1:0];
          sw_left_d  = count_q - n_q;
          count_d    = count_q - n_q;
          sw_ins_d   = 1'b0;
          rdv_d      = 1'b0;
          state_d    = S_SWEEP;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = push || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      time_q      <= '0;
      rdv_q       <= 1'b0;
      found_q     <= 1'b0;
      qset_q      <= 1'b0;
      sw_left_q   <= '0;
      sw_up_q     <= 1'b0;
      sw_ins_q    <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      hold_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      time_q      <= time_d;
      rdv_q       <= rdv_d;
      found_q     <= found_d;
      qset_q      <= qset_d;
      sw_left_q   <= sw_left_d;
      sw_up_q     <= sw_up_d;
      sw_ins_q    <= sw_ins_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      hold_vld_q  <= hold_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    dl_q      <= dl_d;
    chk_q     <= chk_d;
    p_q       <= p_d;
    q_q       <= q_d;
    sw_src_q  <= sw_src_d;
    sw_dst_q  <= sw_dst_d;
    sw_k_q    <= sw_k_d;
    hold_id_q <= hold_id_d;
    if (push) begin
      out_kind_q <= push_kind;
      out_id_q   <= push_id;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign due_id_o      = CLIENT_W'(out_id_q);
  assign last_of_run_o = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count exceeds the queue depth");

  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_REJECT |-> last_of_run_o)
    else $error("rejection not marked as last event");

  a_hold_in_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> (state_q == S_EXP_RD || state_q == S_EXP_CHK ||
                    state_q == S_EXP_END))
    else $error("held expiry event outside the expiry walk");

  a_tick_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && operation_i == OP_TICK |=> time_q == $past(time_q) + TIME_W'(1))
    else $error("tick did not advance the millisecond counter");

endmodule

// ===== verif/deadline_timer_queue_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_checker
// Watches both channels of the timer queue, predicts its events and compares.
// ----------------------------------------------------------------------------
// Every accepted command is applied to a private copy of the sorted timer
// list. The events it causes are queued, and every event transaction that
// leaves the block is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module deadline_timer_queue_checker
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [CLIENT_W-1:0] client_id_i,
  input  logic [DELAY_W-1:0]  delay_ms_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                event_kind_i,
  input  logic [CLIENT_W-1:0] due_id_i,
  input  logic                last_of_run_i,
  output int                  mismatch_count_o,
  output int                  events_waiting_o,
  output int                  events_predicted_o,
  output int                  expiries_seen_o,
  output int                  rejects_seen_o,
  output int                  timers_pending_o
);

  localparam logic [CLIENT_W-1:0] CLIENT_MASK = CLIENT_W'((1 << ID_BITS) - 1);
  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic                kind;
    logic [CLIENT_W-1:0] client;
    logic                last;
  } timer_event_t;

  time_t               now_ms = '0;
  time_t               timer_deadline [QUEUE_DEPTH];
  logic [CLIENT_W-1:0] timer_owner [QUEUE_DEPTH];
  int                  timer_count = 0;
  timer_event_t        due_events [$];

  // Deadline a is strictly earlier than b when a - b is negative as a signed
  // 32-bit number, so the order survives the counter wrapping around.
  function automatic logic falls_before(time_t a, time_t b);
    return $signed(a - b) < 0;
  endfunction

  function automatic void drop_timer(int pos);
    for (int i = pos; i + 1 < timer_count; i++) begin
      timer_deadline[i] = timer_deadline[i+1];
      timer_owner[i]    = timer_owner[i+1];
    end
    timer_count--;
  endfunction

  function automatic int slot_of(logic [CLIENT_W-1:0] client);
    for (int i = 0; i < timer_count; i++) begin
      if (timer_owner[i] == client) return i;
    end
    return timer_count;
  endfunction

  // A new timer goes behind all pending timers with the same deadline.
  function automatic void place_timer(logic [CLIENT_W-1:0] client, time_t deadline);
    int pos;
    pos = 0;
    while (pos < timer_count && !falls_before(deadline, timer_deadline[pos])) pos++;
    for (int i = timer_count; i > pos; i--) begin
      timer_deadline[i] = timer_deadline[i-1];
      timer_owner[i]    = timer_owner[i-1];
    end
    timer_deadline[pos] = deadline;
    timer_owner[pos]    = client;
    timer_count++;
  endfunction

  function automatic void predict_command(logic [OP_W-1:0] op, logic [CLIENT_W-1:0] id,
                                          logic [DELAY_W-1:0] delay);
    logic [CLIENT_W-1:0] client;
    timer_event_t        ev;
    int                  pos;
    int                  fired;
    client = id & CLIENT_MASK;
    fired  = 0;
    case (op)
      OP_SUBSCRIBE: begin
        pos = slot_of(client);
        if (pos < timer_count) begin
          drop_timer(pos);
          place_timer(client, now_ms + delay);
        end else if (timer_count >= QUEUE_DEPTH) begin
          ev.kind   = EV_REJECT;
          ev.client = client;
          ev.last   = 1'b1;
          due_events.push_back(ev);
          events_predicted_o++;
        end else begin
          place_timer(client, now_ms + delay);
        end
      end
      OP_UNSUBSCRIBE: begin
        pos = slot_of(client);
        if (pos < timer_count) drop_timer(pos);
      end
      OP_TICK: begin
        now_ms = now_ms + 1;
        while (timer_count > 0 && fired < QUEUE_DEPTH &&
               !falls_before(now_ms, timer_deadline[0])) begin
          ev.kind   = EV_EXPIRED;
          ev.client = timer_owner[0];
          ev.last   = 1'b0;
          due_events.push_back(ev);
          drop_timer(0);
          fired++;
        end
        if (fired > 0) due_events[due_events.size()-1].last = 1'b1;
        events_predicted_o += fired;
      end
      default: ;
    endcase
  endfunction

  task automatic flag(string what, int want, int got);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_event_t want;
    if (!rst_ni) begin
      now_ms             = '0;
      timer_count        = 0;
      due_events.delete();
      mismatch_count_o   = 0;
      events_predicted_o = 0;
      expiries_seen_o    = 0;
      rejects_seen_o     = 0;
    end else begin
      // Events leaving now were caused by earlier commands, so they are
      // matched before the command of this edge is applied.
      if (out_valid_i && !out_stall_i) begin
        if (due_events.size() == 0) begin
          flag("unexpected event, client", -1, due_id_i);
        end else begin
          want = due_events[0];
          due_events.delete(0);
          if (event_kind_i !== want.kind) flag("event_kind", want.kind, event_kind_i);
          if (due_id_i !== want.client) flag("due_id", want.client, due_id_i);
          if (last_of_run_i !== want.last) flag("last_of_run", want.last, last_of_run_i);
        end
        if (event_kind_i == EV_REJECT) rejects_seen_o++;
        else expiries_seen_o++;
      end
      if (in_valid_i && !in_stall_i) predict_command(operation_i, client_id_i, delay_ms_i);
    end
    events_waiting_o = due_events.size();
    timers_pending_o = timer_count;
  end

endmodule

// ===== verif/deadline_timer_queue_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_top_tb
// Command stimulus and verdict for the deadline timer queue.
// ----------------------------------------------------------------------------
// A short directed run covers the corner cases of the timer list; random
// commands, fill-and-flush sequences and random pacing on both channels
// follow. The checker beside the block predicts and compares every event.
// ----------------------------------------------------------------------------
module deadline_timer_queue_top_tb;
  import dtq_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int ID_BITS        = 8;
  localparam int TOTAL_ITEMS    = 280;
  localparam int SINK_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4 * QUEUE_DEPTH + 40;

  // Code with no command behind it; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                clk_i     = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic [OP_W-1:0]     operation = OP_TICK;
  logic [CLIENT_W-1:0] client_id = '0;
  logic [DELAY_W-1:0]  delay_ms  = '0;
  logic                out_stall = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                event_kind_o;
  logic [CLIENT_W-1:0] due_id_o;
  logic                last_of_run_o;

  int mismatch_count;
  int events_waiting;
  int events_predicted;
  int expiries_seen;
  int rejects_seen;
  int timers_pending;

  int commands_sent = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int calm_items    = 0;

  deadline_timer_queue_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation),
    .client_id_i   (client_id),
    .delay_ms_i    (delay_ms),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .event_kind_o  (event_kind_o),
    .due_id_o      (due_id_o),
    .last_of_run_o (last_of_run_o)
  );

  deadline_timer_queue_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall_o),
    .operation_i        (operation),
    .client_id_i        (client_id),
    .delay_ms_i         (delay_ms),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall),
    .event_kind_i       (event_kind_o),
    .due_id_i           (due_id_o),
    .last_of_run_i      (last_of_run_o),
    .mismatch_count_o   (mismatch_count),
    .events_waiting_o   (events_waiting),
    .events_predicted_o (events_predicted),
    .expiries_seen_o    (expiries_seen),
    .rejects_seen_o     (rejects_seen),
    .timers_pending_o   (timers_pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Mostly no gap or a short one, now and then a long one, and from time to
  // time a calm stretch of back-to-back commands.
  function automatic int sender_gap();
    int r;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_items = $urandom_range(15, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  function automatic int sender_gap_like();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // Most clients come from a small pool so that replacements and removals
  // hit pending timers.
  function automatic logic [CLIENT_W-1:0] random_client();
    if ($urandom_range(0, 99) < 75) return CLIENT_W'($urandom_range(0, 19));
    return CLIENT_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [DELAY_W-1:0] random_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return DELAY_W'($urandom_range(0, 12));
    if (r < 80) return DELAY_W'($urandom_range(13, 300));
    if (r < 92) return DELAY_W'($urandom());
    return {DELAY_W{1'b1}} - DELAY_W'($urandom_range(0, 3));
  endfunction

  task automatic send_command(input logic [OP_W-1:0] op, input logic [CLIENT_W-1:0] client,
                              input logic [DELAY_W-1:0] delay);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    client_id <= client;
    delay_ms  <= delay;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    commands_sent++;
    op_count[op]++;
  endtask

  // Fills the queue, replaces a pending client while full, tries one more
  // client (normally a rejection), then ticks until the short timers expire.
  task automatic fill_then_flush(input int max_delay);
    logic [CLIENT_W-1:0] last_client;
    last_client = '0;
    while (timers_pending < QUEUE_DEPTH) begin
      last_client = CLIENT_W'($urandom_range(0, 255));
      send_command(OP_SUBSCRIBE, last_client, DELAY_W'($urandom_range(0, max_delay)));
    end
    send_command(OP_SUBSCRIBE, last_client, DELAY_W'($urandom_range(0, max_delay)));
    send_command(OP_SUBSCRIBE, CLIENT_W'($urandom_range(0, 255)), random_delay());
    repeat (max_delay + $urandom_range(2, 4)) begin
      send_command(OP_TICK, CLIENT_W'($urandom()), DELAY_W'($urandom()));
    end
  endtask

  initial begin : stimulus
    int  r;
    bit  paused;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    send_command(OP_TICK, 8'h00, '0);              // nothing pending
    send_command(OP_UNSUBSCRIBE, 8'h3C, '0);       // client not pending
    send_command(OP_UNUSED, 8'hFF, '1);
    send_command(OP_SUBSCRIBE, 8'h00, '0);
    send_command(OP_TICK, 8'hFF, '1);              // single expiry
    // A far deadline that crosses the sign of the counter sorts last.
    send_command(OP_SUBSCRIBE, 8'hFF, {DELAY_W{1'b1}});
    // Equal deadlines expire in arrival order; a repeat moves to the back.
    send_command(OP_SUBSCRIBE, 8'h55, 31'd2);
    send_command(OP_SUBSCRIBE, 8'hAA, 31'd2);
    send_command(OP_SUBSCRIBE, 8'h33, 31'd2);
    send_command(OP_SUBSCRIBE, 8'h55, 31'd2);
    send_command(OP_TICK, 8'h00, '0);
    send_command(OP_TICK, 8'h00, '0);
    send_command(OP_UNSUBSCRIBE, 8'hFF, '0);
    send_command(OP_SUBSCRIBE, 8'h80, 31'h4000_0000);
    send_command(OP_UNSUBSCRIBE, 8'h80, '0);
    send_command(OP_TICK, 8'h7F, 31'h2AAA_AAAA);

    fill_then_flush(0);                            // sixteen expiries on one tick
    while (commands_sent < TOTAL_ITEMS) begin
      if (!paused && commands_sent >= 200) begin
        // Let every outstanding event drain before going on.
        paused = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk_i);
        while (events_waiting != 0) @(negedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 4) fill_then_flush($urandom_range(0, 6));
      else if (r < 42) send_command(OP_SUBSCRIBE, random_client(), random_delay());
      else if (r < 55) send_command(OP_UNSUBSCRIBE, random_client(), DELAY_W'($urandom()));
      else if (r < 95) send_command(OP_TICK, CLIENT_W'($urandom()), DELAY_W'($urandom()));
      else send_command(OP_UNUSED, CLIENT_W'($urandom()), DELAY_W'($urandom()));
    end
    in_valid <= 1'b0;

    while (events_waiting != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Run: %0d commands (%0d subscribe, %0d unsubscribe, %0d tick, %0d unused code).",
             commands_sent, op_count[OP_SUBSCRIBE], op_count[OP_UNSUBSCRIBE],
             op_count[OP_TICK], op_count[OP_UNUSED]);
    $display("Run: %0d expiry and %0d full-queue rejection transactions checked.",
             expiries_seen, rejects_seen);
    if (mismatch_count == 0 && events_waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver pacing, with one long hold once the run is under way so that
  // the block backs up and stalls its command channel.
  initial begin : sink_pacing
    int run;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && commands_sent >= 120) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (SINK_HOLD) @(negedge clk_i);
      end
      r_stall: begin
        run = sender_gap_like();
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(negedge clk_i);
        end
      end
      out_stall <= 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      repeat (run) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d events outstanding",
                 $time, quiet, events_waiting);
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
